>>> hdl/ctl_pkg.sv
package ctl_pkg;

  localparam int LINE_LIMIT = 80;
  localparam int TEXT_BYTES = 8;
  localparam int MAX_TOKENS = 128;

  localparam int WORD_SLOTS = 8;

  localparam logic [3:0] CLASS_LBRACE     = 4'd0;
  localparam logic [3:0] CLASS_RBRACE     = 4'd1;
  localparam logic [3:0] CLASS_LPAREN     = 4'd2;
  localparam logic [3:0] CLASS_RPAREN     = 4'd3;
  localparam logic [3:0] CLASS_SEMICOLON  = 4'd4;
  localparam logic [3:0] CLASS_INT        = 4'd5;
  localparam logic [3:0] CLASS_RETURN     = 4'd6;
  localparam logic [3:0] CLASS_UNARY      = 4'd7;
  localparam logic [3:0] CLASS_LITERAL    = 4'd8;
  localparam logic [3:0] CLASS_ASSIGN     = 4'd9;
  localparam logic [3:0] CLASS_IDENTIFIER = 4'd10;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  token_class;
    logic [63:0] token_text;
    logic [3:0]  token_length;
    logic        text_truncated;
    logic [6:0]  token_number;
    logic        last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [1:0] push_count;
    logic       pop;
  } fifo_ctrl_t;

endpackage

>>> hdl/ctl_channels.sv
interface ctl_in_if import ctl_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface ctl_out_if import ctl_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

>>> hdl/ctl_token_fifo.sv
module ctl_token_fifo import ctl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  fifo_ctrl_t ctrl,
  input  out_item_t  first_item,
  input  out_item_t  second_item,
  output out_item_t  head,
  output logic [1:0] count
);

  localparam int DEPTH = 3;

  out_item_t  slots [DEPTH];
  out_item_t  slots_next [DEPTH];
  logic [1:0] count_next;
  logic [1:0] base;

  // Entries shift toward slot 0 on a pop; new items land right behind the survivors.
  always_comb begin
    base = count - {1'b0, ctrl.pop};
    for (int i = 0; i < DEPTH; i++) begin
      slots_next[i] = slots[i];
    end
    if (ctrl.pop) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        slots_next[i] = slots[i + 1];
      end
    end
    for (int i = 0; i < DEPTH; i++) begin
      if (ctrl.push_count != 2'd0 && 2'(i) == base) begin
        slots_next[i] = first_item;
      end
      if (ctrl.push_count == 2'd2 && 2'(i) == base + 2'd1) begin
        slots_next[i] = second_item;
      end
    end
    count_next = base + ctrl.push_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
    for (int i = 0; i < DEPTH; i++) begin
      slots[i] <= slots_next[i];
    end
  end

  assign head = slots[0];

endmodule

>>> hdl/c_subset_token_lexer_unit.sv
// Token lexer for a small C subset. It takes one source byte per cycle while its
// three-entry result queue has room for two more tokens, and returns tokens (class,
// first eight bytes, saturating length, truncation flag, index within the text)
// through that queue, which registers the first token of a byte as the byte is
// accepted. A byte that ends a pending word and is itself a bracket, semicolon or
// unary operator yields two tokens; the queue then holds at least two entries and
// input pauses until it holds fewer than two. With the output side always ready,
// every byte after one that yields at most one token goes in back to back with it.
module c_subset_token_lexer_unit import ctl_pkg::*; (
  input logic        clk,
  input logic        rst,
  ctl_in_if.sink     byte_in,
  ctl_out_if.source  token_out
);

  localparam logic [7:0] CH_NUL       = 8'h00;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_RETURN    = 8'h0D;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_BANG      = 8'h21;
  localparam logic [7:0] CH_LPAREN    = 8'h28;
  localparam logic [7:0] CH_RPAREN    = 8'h29;
  localparam logic [7:0] CH_MINUS     = 8'h2D;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_NINE      = 8'h39;
  localparam logic [7:0] CH_SEMICOLON = 8'h3B;
  localparam logic [7:0] CH_EQUALS    = 8'h3D;
  localparam logic [7:0] CH_LBRACE    = 8'h7B;
  localparam logic [7:0] CH_RBRACE    = 8'h7D;
  localparam logic [7:0] CH_TILDE     = 8'h7E;

  localparam logic [23:0] KW_INT    = 24'h746E69;
  localparam logic [47:0] KW_RETURN = 48'h6E7275746572;

  localparam logic [6:0] TOKEN_CAP    = 7'(MAX_TOKENS - 1);
  localparam logic [6:0] POSITION_CAP = 7'd127;
  localparam logic [6:0] LIMIT        = 7'(LINE_LIMIT);
  localparam logic [3:0] HELD_MAX     = 4'(TEXT_BYTES);
  localparam logic [3:0] LENGTH_CAP   = 4'd15;

  logic [7:0] word_bytes [WORD_SLOTS];
  logic [3:0] word_length;
  logic       all_digits;
  logic [6:0] byte_position;
  logic [6:0] token_count;
  logic       text_stopped;

  logic [7:0]  c;
  logic        eot;
  logic        accept;
  logic        active;
  logic        is_nul;
  logic        is_space;
  logic        is_single;
  logic        is_word;
  logic        is_digit;
  logic        takes_byte;
  logic [3:0]  single_class;
  logic [6:0]  position_inc;
  logic        limit_hit;
  logic [7:0]  fw_bytes [WORD_SLOTS];
  logic [3:0]  fw_length;
  logic        fw_digits;
  logic [63:0] fw_text;
  logic [3:0]  fw_class;
  logic        flush;
  logic [6:0]  count_inc;
  logic [6:0]  single_number;
  out_item_t   word_item;
  out_item_t   single_item;
  out_item_t   first_item;
  out_item_t   second_item;
  fifo_ctrl_t  fifo_ctrl;
  out_item_t   fifo_head;
  logic [1:0]  fifo_count;

  logic [3:0]  word_length_next;
  logic        all_digits_next;
  logic [6:0]  byte_position_next;
  logic [6:0]  token_count_next;
  logic        text_stopped_next;

  assign c      = byte_in.data.char_code;
  assign eot    = byte_in.data.end_of_text;
  assign accept = byte_in.valid && byte_in.ready;

  always_comb begin
    active    = !text_stopped;
    is_nul    = c == CH_NUL;
    is_space  = c == CH_SPACE || c == CH_TAB || c == CH_NEWLINE || c == CH_RETURN;
    is_digit  = c >= CH_ZERO && c <= CH_NINE;
    is_single = 1'b1;
    single_class = CLASS_UNARY;
    unique case (c)
      CH_LBRACE:    single_class = CLASS_LBRACE;
      CH_RBRACE:    single_class = CLASS_RBRACE;
      CH_LPAREN:    single_class = CLASS_LPAREN;
      CH_RPAREN:    single_class = CLASS_RPAREN;
      CH_SEMICOLON: single_class = CLASS_SEMICOLON;
      CH_BANG, CH_TILDE, CH_MINUS: single_class = CLASS_UNARY;
      default:      is_single = 1'b0;
    endcase
    is_word    = !is_nul && !is_space && !is_single;
    takes_byte = active && is_word;

    position_inc = (byte_position == POSITION_CAP) ? byte_position : byte_position + 7'd1;
    limit_hit    = active && !is_nul && position_inc >= LIMIT;

    // The word that may be flushed this cycle already includes a word byte.
    for (int i = 0; i < WORD_SLOTS; i++) begin
      fw_bytes[i] = word_bytes[i];
    end
    if (takes_byte && word_length < HELD_MAX) begin
      fw_bytes[word_length[2:0]] = c;
    end
    if (takes_byte) begin
      fw_length = (word_length == LENGTH_CAP) ? word_length : word_length + 4'd1;
    end else begin
      fw_length = word_length;
    end
    fw_digits = all_digits && (!takes_byte || is_digit);

    fw_text = 64'd0;
    for (int i = 0; i < WORD_SLOTS; i++) begin
      if (i < TEXT_BYTES && 4'(i) < fw_length) begin
        fw_text[8*i +: 8] = fw_bytes[i];
      end
    end

    priority if (fw_length == 4'd3 && fw_text[23:0] == KW_INT) begin
      fw_class = CLASS_INT;
    end else if (fw_length == 4'd6 && fw_text[47:0] == KW_RETURN) begin
      fw_class = CLASS_RETURN;
    end else if (fw_digits) begin
      fw_class = CLASS_LITERAL;
    end else if (fw_length == 4'd1 && fw_text[7:0] == CH_EQUALS) begin
      fw_class = CLASS_ASSIGN;
    end else begin
      fw_class = CLASS_IDENTIFIER;
    end

    flush = fw_length != 4'd0 &&
            (eot || (active && (is_nul || is_space || is_single || limit_hit)));

    count_inc     = (token_count == TOKEN_CAP) ? token_count : token_count + 7'd1;
    single_number = flush ? count_inc : token_count;

    word_item.token_class    = fw_class;
    word_item.token_text     = fw_text;
    word_item.token_length   = fw_length;
    word_item.text_truncated = fw_length > HELD_MAX;
    word_item.token_number   = token_count;
    word_item.last_of_run    = !(active && is_single);

    single_item.token_class    = single_class;
    single_item.token_text     = {56'd0, c};
    single_item.token_length   = 4'd1;
    single_item.text_truncated = 1'b0;
    single_item.token_number   = single_number;
    single_item.last_of_run    = 1'b1;

    first_item  = flush ? word_item : single_item;
    second_item = single_item;

    fifo_ctrl.pop = token_out.ready && fifo_count != 2'd0;
    fifo_ctrl.push_count = 2'd0;
    if (accept) begin
      fifo_ctrl.push_count = {1'b0, flush} + {1'b0, active && is_single};
    end

    // Next state of the word and per-text counters.
    if (eot) begin
      word_length_next   = 4'd0;
      all_digits_next    = 1'b1;
      byte_position_next = 7'd0;
      token_count_next   = 7'd0;
      text_stopped_next  = 1'b0;
    end else begin
      if (flush) begin
        word_length_next = 4'd0;
        all_digits_next  = 1'b1;
      end else begin
        word_length_next = fw_length;
        all_digits_next  = fw_digits;
      end
      byte_position_next = (active && !is_nul) ? position_inc : byte_position;
      text_stopped_next  = text_stopped || (active && (is_nul || limit_hit));
      token_count_next   = token_count;
      if (flush && active && is_single) begin
        token_count_next = (single_number == TOKEN_CAP) ? single_number : single_number + 7'd1;
      end else if (flush || (active && is_single)) begin
        token_count_next = count_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_length   <= 4'd0;
      all_digits    <= 1'b1;
      byte_position <= 7'd0;
      token_count   <= 7'd0;
      text_stopped  <= 1'b0;
    end else if (accept) begin
      word_length   <= word_length_next;
      all_digits    <= all_digits_next;
      byte_position <= byte_position_next;
      token_count   <= token_count_next;
      text_stopped  <= text_stopped_next;
    end
    if (accept) begin
      for (int i = 0; i < WORD_SLOTS; i++) begin
        word_bytes[i] <= fw_bytes[i];
      end
    end
  end

  ctl_token_fifo u_token_fifo (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (fifo_ctrl),
    .first_item  (first_item),
    .second_item (second_item),
    .head        (fifo_head),
    .count       (fifo_count)
  );

  // Room for two more items is kept before a byte is taken.
  assign byte_in.ready   = fifo_count < 2'd2;
  assign token_out.valid = fifo_count != 2'd0;
  assign token_out.data  = fifo_head;

endmodule

>>> verif/tb_c_subset_token_lexer_unit.sv
module tb_c_subset_token_lexer_unit;
  import ctl_pkg::*;

  localparam int DIRECTED_ROWS = 25;
  localparam int RANDOM_BYTES  = 1100;
  localparam int CALM_FROM     = 950;
  localparam int HOLD_AT       = 300;
  localparam int HOLD_CYCLES   = 200;
  localparam int DRAIN_CYCLES  = 20;
  localparam int TIMEOUT       = 5_000_000;

  localparam logic TYPED     = 1'b1;
  localparam logic PREDICTED = 1'b0;
  localparam out_item_t NO_TOKEN = '0;

  typedef struct packed {
    logic [7:0] ch;
    logic       eot;
    logic       typed;
    out_item_t  token;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;

  ctl_in_if  byte_in ();
  ctl_out_if token_out ();

  c_subset_token_lexer_unit dut (
    .clk(clk),
    .rst(rst),
    .byte_in(byte_in),
    .token_out(token_out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Lexer state as the predictor sees it.
  logic [7:0] held_bytes [8];
  logic [3:0] word_len    = '0;
  logic       digits_only = 1'b1;
  logic [6:0] text_pos    = '0;
  logic [6:0] tok_index   = '0;
  logic       halted      = 1'b0;

  out_item_t  fresh_tokens [$];
  out_item_t  expected_tokens [$];
  in_item_t   source_bytes [$];
  stim_row_t  directed [DIRECTED_ROWS];

  int  rows_taken = 0;
  int  live_random_bytes = 0;
  int  mismatches = 0;
  bit  hold_active = 1'b0;
  bit  held_long = 1'b0;

  function automatic void emit_token(logic [3:0] cls, logic [63:0] txt, logic [3:0] len,
                                     logic trunc);
    out_item_t tk;
    tk.token_class    = cls;
    tk.token_text     = txt;
    tk.token_length   = len;
    tk.text_truncated = trunc;
    tk.token_number   = tok_index;
    tk.last_of_run    = 1'b0;
    fresh_tokens.push_back(tk);
    if (tok_index < MAX_TOKENS - 1) tok_index++;
  endfunction

  function automatic void flush_word();
    logic [63:0] txt;
    logic [3:0]  cls;
    int          held;
    int          i;
    if (word_len == 0) return;
    txt = '0;
    held = (word_len < TEXT_BYTES) ? word_len : TEXT_BYTES;
    for (i = 0; i < held; i++) txt[8*i +: 8] = held_bytes[i];
    if (word_len == 3 && {held_bytes[0], held_bytes[1], held_bytes[2]} == "int") begin
      cls = CLASS_INT;
    end else if (word_len == 6 && {held_bytes[0], held_bytes[1], held_bytes[2],
                                   held_bytes[3], held_bytes[4], held_bytes[5]} == "return") begin
      cls = CLASS_RETURN;
    end else if (digits_only) begin
      cls = CLASS_LITERAL;
    end else if (word_len == 1 && held_bytes[0] == "=") begin
      cls = CLASS_ASSIGN;
    end else begin
      cls = CLASS_IDENTIFIER;
    end
    emit_token(cls, txt, word_len, word_len > TEXT_BYTES);
    word_len = '0;
    digits_only = 1'b1;
  endfunction

  function automatic bit punct_class(input logic [7:0] ch, output logic [3:0] cls);
    bit found;
    found = 1'b1;
    cls = CLASS_IDENTIFIER;
    case (ch)
      "{": cls = CLASS_LBRACE;
      "}": cls = CLASS_RBRACE;
      "(": cls = CLASS_LPAREN;
      ")": cls = CLASS_RPAREN;
      ";": cls = CLASS_SEMICOLON;
      "!", "~", "-": cls = CLASS_UNARY;
      default: found = 1'b0;
    endcase
    return found;
  endfunction

  // Works out the tokens one byte causes; returns 1 when the byte is ignored.
  function automatic bit lex_byte(in_item_t it);
    logic [7:0] ch;
    logic [3:0] cls;
    bit         ignored;
    ch = it.char_code;
    fresh_tokens.delete();
    ignored = halted && !it.end_of_text;
    if (!halted) begin
      if (ch == 8'h00) begin
        flush_word();
        halted = 1'b1;
      end else begin
        if (ch == " " || ch == 8'h09 || ch == 8'h0A || ch == 8'h0D) begin
          flush_word();
        end else if (punct_class(ch, cls)) begin
          flush_word();
          emit_token(cls, {56'd0, ch}, 4'd1, 1'b0);
        end else begin
          if (word_len < TEXT_BYTES) held_bytes[word_len[2:0]] = ch;
          if (word_len < 15) word_len++;
          if (ch < "0" || ch > "9") digits_only = 1'b0;
        end
        if (text_pos < 127) text_pos++;
        if (text_pos >= LINE_LIMIT) begin
          flush_word();
          halted = 1'b1;
        end
      end
    end
    if (it.end_of_text) begin
      flush_word();
      word_len = '0;
      digits_only = 1'b1;
      text_pos = '0;
      tok_index = '0;
      halted = 1'b0;
    end
    return ignored;
  endfunction

  function automatic void take_byte(in_item_t it);
    out_item_t tk;
    bit        ignored;
    ignored = lex_byte(it);
    if (fresh_tokens.size() != 0) begin
      tk = fresh_tokens.pop_back();
      tk.last_of_run = 1'b1;
      fresh_tokens.push_back(tk);
    end
    if (rows_taken < DIRECTED_ROWS) begin
      // Typed rows replace the prediction with the value written in the table.
      if (directed[rows_taken].typed) begin
        fresh_tokens.delete();
        if (directed[rows_taken].token != NO_TOKEN)
          fresh_tokens.push_back(directed[rows_taken].token);
      end
      rows_taken++;
    end else if (!ignored) begin
      live_random_bytes++;
    end
    foreach (fresh_tokens[k]) expected_tokens.push_back(fresh_tokens[k]);
  endfunction

  function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  function automatic void check_token(out_item_t got);
    out_item_t want;
    if (expected_tokens.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected token, expected none, actual %h", $time, got);
      return;
    end
    want = expected_tokens.pop_front();
    compare_field("token_class", want.token_class, got.token_class);
    compare_field("token_text", want.token_text, got.token_text);
    compare_field("token_length", want.token_length, got.token_length);
    compare_field("text_truncated", want.text_truncated, got.text_truncated);
    compare_field("token_number", want.token_number, got.token_number);
    compare_field("last_of_run", want.last_of_run, got.last_of_run);
  endfunction

  // Everything settles after the rising edge, so the falling edge sees stable values.
  always @(negedge clk) begin
    if (!rst) begin
      if (token_out.valid && token_out.ready) check_token(token_out.data);
      if (byte_in.valid && byte_in.ready) take_byte(byte_in.data);
    end
  end

  function automatic out_item_t tok(logic [3:0] cls, logic [63:0] txt, logic [3:0] len,
                                    logic [6:0] num);
    return {cls, txt, len, 1'b0, num, 1'b1};
  endfunction

  function automatic void put(logic [7:0] ch, logic eot);
    in_item_t it;
    it.char_code = ch;
    it.end_of_text = eot;
    source_bytes.push_back(it);
  endfunction

  function automatic void put_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) put(s[i], 1'b0);
  endfunction

  // Builds one text of mostly well-formed source with random content.
  function automatic void compose_text();
    string    letters = "abcdefghijklmnopqrstuvwxyz_";
    string    singles = "{}();!~-";
    string    blanks = " \t\n\r";
    int       goal;
    int       first;
    int       kind;
    int       n;
    int       i;
    in_item_t it;
    goal = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 110) : $urandom_range(4, 40);
    first = source_bytes.size();
    while (source_bytes.size() - first < goal) begin
      kind = $urandom_range(0, 11);
      case (kind)
        0: put_text("int");
        1: put_text("return");
        2: begin
          n = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
          put(letters[$urandom_range(0, 26)], 1'b0);
          for (i = 1; i < n; i++)
            put(($urandom_range(0, 3) == 0) ? 8'($urandom_range("0", "9"))
                                            : letters[$urandom_range(0, 26)], 1'b0);
        end
        3: begin
          case ($urandom_range(0, 7))
            0: put_text("in");
            1: put_text("intx");
            2: put_text("Int");
            3: put_text("retur");
            4: put_text("returnx");
            5: put_text("==");
            6: put_text("x=");
            default: put_text("i");
          endcase
        end
        4: begin
          n = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
          for (i = 0; i < n; i++) put(8'($urandom_range("0", "9")), 1'b0);
        end
        5: put("=", 1'b0);
        6: put(singles[$urandom_range(0, 7)], 1'b0);
        7: put(blanks[$urandom_range(0, 3)], 1'b0);
        8: begin
          n = $urandom_range(1, 10);
          for (i = 0; i < n; i++) put(8'($urandom_range(1, 255)), 1'b0);
        end
        9: begin
          n = $urandom_range(1, 6);
          for (i = 0; i < n; i++) put(8'($urandom_range("0", "9")), 1'b0);
          put(($urandom_range(0, 1) == 0) ? 8'($urandom_range(128, 255))
                                          : letters[$urandom_range(0, 26)], 1'b0);
        end
        10: put(blanks[$urandom_range(0, 3)], 1'b0);
        default: put(8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0));
      endcase
      if ((kind <= 4 || kind == 8 || kind == 9) && $urandom_range(0, 3) != 0)
        put(($urandom_range(0, 2) == 0) ? singles[$urandom_range(0, 7)]
                                        : blanks[$urandom_range(0, 3)], 1'b0);
    end
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        it = source_bytes.pop_back();
        it.end_of_text = 1'b1;
        source_bytes.push_back(it);
      end
      6: begin
        put(8'h00, 1'b0);
        n = $urandom_range(0, 4);
        for (i = 0; i < n; i++) put(8'($urandom_range(0, 255)), 1'b0);
        put(8'($urandom_range(0, 255)), 1'b1);
      end
      7: put(8'($urandom_range(0, 255)), 1'b1);
      default: ;
    endcase
  endfunction

  // The handshake completes at the rising edge after a falling edge that sees ready.
  task automatic offer_byte(in_item_t it);
    byte_in.valid <= 1'b1;
    byte_in.data <= it;
    @(negedge clk);
    while (!byte_in.ready) @(negedge clk);
    @(posedge clk);
  endtask

  initial begin
    rst = 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin
    int       r;
    in_item_t it;
    byte_in.valid <= 1'b0;
    byte_in.data <= '0;

    directed[0]  = {"{", 1'b0, TYPED, tok(CLASS_LBRACE, "{", 4'd1, 7'd0)};
    directed[1]  = {"}", 1'b0, TYPED, tok(CLASS_RBRACE, "}", 4'd1, 7'd1)};
    directed[2]  = {"(", 1'b0, TYPED, tok(CLASS_LPAREN, "(", 4'd1, 7'd2)};
    directed[3]  = {")", 1'b0, TYPED, tok(CLASS_RPAREN, ")", 4'd1, 7'd3)};
    directed[4]  = {";", 1'b0, TYPED, tok(CLASS_SEMICOLON, ";", 4'd1, 7'd4)};
    directed[5]  = {"!", 1'b0, TYPED, tok(CLASS_UNARY, "!", 4'd1, 7'd5)};
    directed[6]  = {"~", 1'b0, TYPED, tok(CLASS_UNARY, "~", 4'd1, 7'd6)};
    directed[7]  = {"-", 1'b0, TYPED, tok(CLASS_UNARY, "-", 4'd1, 7'd7)};
    directed[8]  = {"i", 1'b0, TYPED, NO_TOKEN};
    directed[9]  = {"n", 1'b0, TYPED, NO_TOKEN};
    directed[10] = {"t", 1'b0, TYPED, NO_TOKEN};
    // Token text holds the first byte in the low bits.
    directed[11] = {" ", 1'b0, TYPED, tok(CLASS_INT, 64'h746E69, 4'd3, 7'd8)};
    directed[12] = {"r", 1'b0, PREDICTED, NO_TOKEN};
    directed[13] = {"e", 1'b0, PREDICTED, NO_TOKEN};
    directed[14] = {"t", 1'b0, PREDICTED, NO_TOKEN};
    directed[15] = {"u", 1'b0, PREDICTED, NO_TOKEN};
    directed[16] = {"r", 1'b0, PREDICTED, NO_TOKEN};
    directed[17] = {"n", 1'b0, PREDICTED, NO_TOKEN};
    // One byte that ends a word and is a token itself gives two results.
    directed[18] = {"(", 1'b0, PREDICTED, NO_TOKEN};
    directed[19] = {"=", 1'b0, PREDICTED, NO_TOKEN};
    directed[20] = {8'h09, 1'b0, TYPED, tok(CLASS_ASSIGN, "=", 4'd1, 7'd11)};
    directed[21] = {"9", 1'b0, TYPED, NO_TOKEN};
    directed[22] = {8'h00, 1'b0, TYPED, tok(CLASS_LITERAL, "9", 4'd1, 7'd12)};
    directed[23] = {8'hFF, 1'b0, TYPED, NO_TOKEN};
    directed[24] = {"x", 1'b1, TYPED, NO_TOKEN};

    @(posedge clk);
    while (rst) @(posedge clk);

    for (r = 0; r < DIRECTED_ROWS; r++) begin
      it.char_code = directed[r].ch;
      it.end_of_text = directed[r].eot;
      offer_byte(it);
    end

    while (live_random_bytes < RANDOM_BYTES) begin
      if (source_bytes.size() == 0) compose_text();
      if (live_random_bytes < CALM_FROM && !hold_active && $urandom_range(0, 7) == 0) begin
        byte_in.valid <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      offer_byte(source_bytes.pop_front());
    end
    byte_in.valid <= 1'b0;

    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_tokens.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    token_out.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!held_long && live_random_bytes >= HOLD_AT) begin
        // Long hold-off so the result queue fills and the input stalls.
        held_long = 1'b1;
        hold_active = 1'b1;
        token_out.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active = 1'b0;
      end else if (live_random_bytes >= CALM_FROM || $urandom_range(0, 3) != 0) begin
        token_out.ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        token_out.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  initial begin
    #(TIMEOUT);
    $display("FAILURE");
    $finish;
  end

endmodule
